// ===== rtl/wto_pkg.sv =====
package wto_pkg;

    localparam int TABLE_BITS  = 10;
    localparam int FRAC_BITS   = 16;
    localparam int SAMPLE_BITS = 16;

    localparam int TABLE_LEN     = 1 << TABLE_BITS;
    localparam int QUARTER_LEN   = TABLE_LEN / 4;
    localparam int PHASE_BITS    = TABLE_BITS + FRAC_BITS;
    localparam int PROD_BITS     = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = PHASE_BITS;

    localparam longint FULL_SCALE  = 64'sd1 <<< (SAMPLE_BITS - 1);
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam int     SINE_SHIFT  = 30 - (SAMPLE_BITS - 1);

    localparam logic [CFG_IDX_BITS-1:0] REG_WAVE_SHAPE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_INC  = CFG_IDX_BITS'(1);

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_TRI    = 2'd2,
        WAVE_SQUARE = 2'd3
    } t_wave_shape;

    typedef logic        [TABLE_BITS-1:0]  t_index;
    typedef logic        [FRAC_BITS-1:0]   t_frac;
    typedef logic        [PHASE_BITS-1:0]  t_phase;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample t_sine_rom [TABLE_LEN];

    // taylor denominators (2n)(2n+1)
    localparam logic [63:0] TAYLOR_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] NEG_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // |sin(pi/2 * k / Q)| in sample units, q30 series
    function automatic logic [63:0] sine_quarter(input logic [TABLE_BITS:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (64'(HALF_PI_Q30) * 64'(k)) >> (TABLE_BITS - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum + (64'd1 << (SINE_SHIFT - 1))) >> SINE_SHIFT;
        if (v > 64'(FULL_SCALE - 1)) begin
            v = 64'(FULL_SCALE - 1);
        end
        return v;
    endfunction

    function automatic t_sine_rom build_sine();
        t_sine_rom                rom;
        logic [TABLE_BITS-1:0]    i;
        logic [1:0]               quad;
        logic [TABLE_BITS:0]      r;
        logic [TABLE_BITS:0]      k;
        logic [63:0]              m;
        logic [SAMPLE_BITS-1:0]   mag;
        for (int n = 0; n < TABLE_LEN; n++) begin
            i    = TABLE_BITS'(n);
            quad = i[TABLE_BITS-1 -: 2];
            r    = (TABLE_BITS+1)'(i[TABLE_BITS-3:0]);
            k    = quad[0] ? (TABLE_BITS+1)'(QUARTER_LEN) - r : r;
            m    = sine_quarter(k);
            mag  = m[SAMPLE_BITS-1:0];
            rom[n] = quad[1] ? t_sample'(-mag) : t_sample'(mag);
        end
        return rom;
    endfunction

    function automatic t_sample saw_entry(input t_index i);
        logic [TABLE_BITS+SAMPLE_BITS:0] w;
        w = (TABLE_BITS+SAMPLE_BITS+1)'(i) + 1'b1;
        w = w << SAMPLE_BITS;
        w = w >> TABLE_BITS;
        if (w[SAMPLE_BITS]) begin
            return t_sample'(POS_MAX);
        end
        return t_sample'({~w[SAMPLE_BITS-1], w[SAMPLE_BITS-2:0]});
    endfunction

    function automatic t_sample tri_entry(input t_index i);
        logic [TABLE_BITS+SAMPLE_BITS:0] mag;
        logic [TABLE_BITS+SAMPLE_BITS:0] v;
        logic [TABLE_BITS+SAMPLE_BITS:0] wi;
        logic                            neg;
        wi = (TABLE_BITS+SAMPLE_BITS+1)'(i);
        if (wi < (TABLE_BITS+SAMPLE_BITS+1)'(QUARTER_LEN)) begin
            mag = wi + 1'b1;
            neg = 1'b0;
        end else if (wi < (TABLE_BITS+SAMPLE_BITS+1)'(2 * QUARTER_LEN)) begin
            mag = (TABLE_BITS+SAMPLE_BITS+1)'(2 * QUARTER_LEN - 1) - wi;
            neg = 1'b0;
        end else if (wi < (TABLE_BITS+SAMPLE_BITS+1)'(3 * QUARTER_LEN)) begin
            mag = wi - (TABLE_BITS+SAMPLE_BITS+1)'(2 * QUARTER_LEN - 1);
            neg = 1'b1;
        end else begin
            mag = (TABLE_BITS+SAMPLE_BITS+1)'(4 * QUARTER_LEN - 1) - wi;
            neg = 1'b1;
        end
        v = (mag << (SAMPLE_BITS - 1)) >> (TABLE_BITS - 2);
        if (neg) begin
            v = '0 - v;
            return t_sample'(v[SAMPLE_BITS-1:0]);
        end
        if (v[SAMPLE_BITS-1] || v[SAMPLE_BITS]) begin
            return t_sample'(POS_MAX);
        end
        return t_sample'(v[SAMPLE_BITS-1:0]);
    endfunction

    function automatic t_sample square_entry(input t_index i);
        return i[TABLE_BITS-1] ? t_sample'(NEG_MAX) : t_sample'(POS_MAX);
    endfunction

endpackage

// ===== rtl/wto_table.sv =====
module wto_table
    import wto_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  t_wave_shape i_shape,
    input  t_index      i_index,
    output t_sample     o_entry_a,
    output t_sample     o_entry_b
);

    localparam t_sine_rom SINE_ROM = build_sine();

    t_index  index_b;
    t_sample r_entry_a;
    t_sample r_entry_b;

    assign index_b = i_index + t_index'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (i_shape)
                WAVE_SINE: begin
                    r_entry_a <= SINE_ROM[i_index];
                    r_entry_b <= SINE_ROM[index_b];
                end
                WAVE_SAW: begin
                    r_entry_a <= saw_entry(i_index);
                    r_entry_b <= saw_entry(index_b);
                end
                WAVE_TRI: begin
                    r_entry_a <= tri_entry(i_index);
                    r_entry_b <= tri_entry(index_b);
                end
                default: begin
                    r_entry_a <= square_entry(i_index);
                    r_entry_b <= square_entry(index_b);
                end
            endcase
        end
    end

    assign o_entry_a = r_entry_a;
    assign o_entry_b = r_entry_b;

endmodule

// ===== rtl/wavetable_oscillator_interp_top.sv =====
// throughput: one sample per cycle while the output is not stalled, set by the
// registered two-port table read and the weight multiply stage, each taking a
// new beat every cycle; a beat passes the table, multiply and output registers
// reset: phase, wave shape (sine) and increment cleared, pipeline emptied;
// the sine table is constant and needs no clearing
module wavetable_oscillator_interp_top
    import wto_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_stop_request,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_value,
    output logic                     o_playing
);

    t_wave_shape r_shape;
    t_phase      r_inc;
    t_phase      r_phase;

    logic adv1, adv2, adv3, accept;
    t_phase phase_now;

    logic  r_s1_valid;
    t_frac r_s1_frac;
    logic  r_s1_play;

    logic                 r_s2_valid;
    logic [PROD_BITS-1:0] r_s2_pa;
    logic [PROD_BITS-1:0] r_s2_pb;
    logic                 r_s2_play;

    logic    r_out_valid;
    t_sample r_out_sample;
    logic    r_out_play;

    t_sample entry_a, entry_b;
    logic [SAMPLE_BITS-1:0] ua, ub;
    logic [FRAC_BITS:0]     wa;
    logic [PROD_BITS-1:0]   acc;

    assign adv3   = !r_out_valid || i_out_ready;
    assign adv2   = !r_s2_valid || adv3;
    assign adv1   = !r_s1_valid || adv2;
    assign accept = i_in_valid && adv1;

    assign phase_now = i_stop_request ? '0 : r_phase;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= WAVE_SINE;
            r_inc   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WAVE_SHAPE: r_shape <= t_wave_shape'(i_cfg_wdata[1:0]);
                REG_PHASE_INC:  r_inc   <= t_phase'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // phase accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (accept) begin
            r_phase <= phase_now + r_inc;
        end
    end

    // stage 1: table read
    wto_table u_table (
        .i_clk     (i_clk),
        .i_en      (adv1),
        .i_shape   (r_shape),
        .i_index   (phase_now[PHASE_BITS-1:FRAC_BITS]),
        .o_entry_a (entry_a),
        .o_entry_b (entry_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv1) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_frac <= phase_now[FRAC_BITS-1:0];
            r_s1_play <= (r_inc != '0);
        end
    end

    // stage 2: weight multiplies on offset-binary entries
    assign ua = {~entry_a[SAMPLE_BITS-1], entry_a[SAMPLE_BITS-2:0]};
    assign ub = {~entry_b[SAMPLE_BITS-1], entry_b[SAMPLE_BITS-2:0]};
    assign wa = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, r_s1_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_pa   <= PROD_BITS'(ua) * PROD_BITS'(wa);
            r_s2_pb   <= PROD_BITS'(ub) * PROD_BITS'(r_s1_frac);
            r_s2_play <= r_s1_play;
        end
    end

    // stage 3: sum, round, back to two's complement
    assign acc = r_s2_pa + r_s2_pb + (PROD_BITS'(1) << (FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_out_sample <= t_sample'({~acc[FRAC_BITS+SAMPLE_BITS-1],
                                       acc[FRAC_BITS+SAMPLE_BITS-2:FRAC_BITS]});
            r_out_play   <= r_s2_play;
        end
    end

    assign o_in_ready     = adv1;
    assign o_out_valid    = r_out_valid;
    assign o_sample_value = r_out_sample;
    assign o_playing      = r_out_play;

endmodule

// ===== test/tb_wavetable_oscillator_interp_top.sv =====
`timescale 1ns / 1ps

module tb_wavetable_oscillator_interp_top;
    import wto_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = CFG_IDX_BITS'(3);
    localparam logic [PHASE_BITS-1:0]   INC_MAX     = '1;

    typedef struct {
        t_sample sample;
        logic    playing;
    } t_osc_beat;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic                     i_stop_request;
    logic                     o_out_valid;
    logic                     i_out_ready;
    t_sample                  o_sample_value;
    logic                     o_playing;

    // oscillator prediction state
    longint      sine_tab [TABLE_LEN];
    t_wave_shape osc_shape;
    t_phase      osc_inc;
    t_phase      osc_phase;

    t_osc_beat   pending_samples [$];
    int unsigned mismatches;
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int          hold_left;

    wavetable_oscillator_interp_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_stop_request (i_stop_request),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_value (o_sample_value),
        .o_playing      (o_playing)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // sine rom from quarter-wave magnitudes
    initial begin : sine_rom
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned acc;
        longint unsigned mag [QUARTER_LEN+1];
        longint unsigned m;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (longint'(HALF_PI_Q30) * k) / QUARTER_LEN;
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            acc = (acc + (64'd1 << (SINE_SHIFT - 1))) >> SINE_SHIFT;
            mag[k] = (acc > FULL_SCALE - 1) ? FULL_SCALE - 1 : acc;
        end
        for (int i = 0; i < TABLE_LEN; i++) begin
            m = ((i / QUARTER_LEN) % 2 == 1) ? mag[QUARTER_LEN - (i % QUARTER_LEN)]
                                             : mag[i % QUARTER_LEN];
            sine_tab[i] = (i / QUARTER_LEN >= 2) ? -longint'(m) : longint'(m);
        end
    end

    function automatic longint wave_point(input t_wave_shape shape, input longint i);
        longint t;
        longint v;
        i = i % TABLE_LEN;
        case (shape)
            WAVE_SINE: begin
                return sine_tab[i];
            end
            WAVE_SAW: begin
                v = (((i + 1) << SAMPLE_BITS) >> TABLE_BITS) - FULL_SCALE;
                return (v > FULL_SCALE - 1) ? FULL_SCALE - 1 : v;
            end
            WAVE_TRI: begin
                if (i < QUARTER_LEN) begin
                    t = i + 1;
                end else if (i < 3 * QUARTER_LEN) begin
                    t = 2 * QUARTER_LEN - 1 - i;
                end else begin
                    t = i + 1 - 4 * QUARTER_LEN;
                end
                if (t >= 0) begin
                    v = (t << (SAMPLE_BITS - 1)) >> (TABLE_BITS - 2);
                    return (v > FULL_SCALE - 1) ? FULL_SCALE - 1 : v;
                end
                return -(((-t) << (SAMPLE_BITS - 1)) >> (TABLE_BITS - 2));
            end
            default: begin
                return (i < TABLE_LEN / 2) ? FULL_SCALE - 1 : -FULL_SCALE;
            end
        endcase
    endfunction

    // one sample from the current phase (zeroed on stop), then phase advance
    function automatic t_osc_beat advance_oscillator(input logic stop);
        t_osc_beat       beat;
        longint          idx;
        longint unsigned frac;
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned acc;
        if (stop) begin
            osc_phase = '0;
        end
        idx  = longint'(osc_phase[PHASE_BITS-1:FRAC_BITS]);
        frac = longint'(osc_phase[FRAC_BITS-1:0]);
        ua   = wave_point(osc_shape, idx) + FULL_SCALE;
        ub   = wave_point(osc_shape, idx + 1) + FULL_SCALE;
        acc  = ua * ((64'd1 << FRAC_BITS) - frac) + ub * frac + (64'd1 << (FRAC_BITS - 1));
        acc  = acc >> FRAC_BITS;
        beat.sample  = t_sample'(acc - FULL_SCALE);
        beat.playing = (osc_inc != '0);
        osc_phase = osc_phase + osc_inc;
        return beat;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        if (idx == REG_WAVE_SHAPE) begin
            osc_shape = t_wave_shape'(data[1:0]);
        end else if (idx == REG_PHASE_INC) begin
            osc_inc = t_phase'(data);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_beat(input logic stop);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_stop_request <= stop;
        do @(posedge i_clk); while (!o_in_ready);
        pending_samples.push_back(advance_oscillator(stop));
        @(negedge i_clk);
    endtask

    task automatic wait_for_samples();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    task automatic test_reset_state();
        send_beat(1'b0);
        send_beat(1'b1);
        wait_for_samples();
    endtask

    // full-range increment lands on the last entry with the top fraction
    task automatic test_shape_edges();
        for (int w = WAVE_SINE; w <= WAVE_SQUARE; w++) begin
            write_reg(REG_WAVE_SHAPE, CFG_DATA_BITS'(w));
            write_reg(REG_PHASE_INC, INC_MAX);
            send_beat(1'b1);
            send_beat(1'b0);
            send_beat(1'b0);
            wait_for_samples();
        end
    endtask

    task automatic test_half_step();
        write_reg(REG_WAVE_SHAPE, CFG_DATA_BITS'(WAVE_TRI));
        write_reg(REG_PHASE_INC, CFG_DATA_BITS'(1 << (FRAC_BITS - 1)));
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);
        wait_for_samples();
    endtask

    // spare indexes ignored, upper shape bits ignored
    task automatic test_register_decode();
        write_reg(REG_SPARE_2, CFG_DATA_BITS'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_BITS'($urandom));
        write_reg(REG_WAVE_SHAPE, {{(CFG_DATA_BITS-2){1'b1}}, WAVE_SAW});
        send_beat(1'b0);
        send_beat(1'b0);
        wait_for_samples();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        write_reg(REG_WAVE_SHAPE, CFG_DATA_BITS'(WAVE_SINE));
        write_reg(REG_PHASE_INC, CFG_DATA_BITS'($urandom));
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 40; n++) begin
            send_beat($urandom_range(99) < 3);
        end
        // sender pauses until the pipe is empty, then resumes the same phase
        wait_for_samples();
        for (int n = 0; n < 20; n++) begin
            send_beat($urandom_range(99) < 3);
        end
        wait_for_samples();
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_BITS-1:0] inc;
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: set_idling(0, 0);
                1: set_idling(55, 0);
                2: set_idling(0, 55);
                default: set_idling(23, 23);
            endcase
            for (int s = 0; s < 8; s++) begin
                case ($urandom_range(5))
                    0: inc = '0;
                    1: inc = INC_MAX;
                    2: inc = CFG_DATA_BITS'($urandom_range(1, 32'h3FFFF));
                    3: inc = CFG_DATA_BITS'($urandom_range((1 << FRAC_BITS) - 16,
                                                           (1 << FRAC_BITS) + 16));
                    default: inc = CFG_DATA_BITS'($urandom);
                endcase
                if ($urandom_range(3) == 0) begin
                    write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                              CFG_DATA_BITS'($urandom));
                end
                write_reg(REG_WAVE_SHAPE, CFG_DATA_BITS'($urandom));
                write_reg(REG_PHASE_INC, inc);
                for (int n = 0; n < 40; n++) begin
                    send_beat($urandom_range(99) < 3);
                end
                wait_for_samples();
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_stop_request = 1'b0;
        osc_shape      = WAVE_SINE;
        osc_inc        = '0;
        osc_phase      = '0;
        mismatches     = 0;
        hold_left      = 0;
        set_idling(0, 0);
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_shape_edges();
        test_half_step();
        test_register_decode();
        test_backpressure();
        test_random_traffic();
        wait_for_samples();

        if (mismatches == 0) begin
            $display("wavetable_oscillator_interp_top test passed");
        end else begin
            $display("wavetable_oscillator_interp_top test failed");
        end
        $finish;
    end

    initial begin : sink
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left    = hold_left - 1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_samples
        t_osc_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_samples.size() == 0) begin
                $display("%0t unexpected beat: expected none, got sample %0d playing %0b",
                         $time, o_sample_value, o_playing);
                mismatches++;
            end else begin
                want = pending_samples.pop_front();
                if (o_sample_value !== want.sample) begin
                    $display("%0t sample mismatch: expected %0d, got %0d",
                             $time, want.sample, o_sample_value);
                    mismatches++;
                end
                if (o_playing !== want.playing) begin
                    $display("%0t playing mismatch: expected %0b, got %0b",
                             $time, want.playing, o_playing);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("%0t no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("wavetable_oscillator_interp_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wto_pkg.sv
rtl/wto_table.sv
rtl/wavetable_oscillator_interp_top.sv
test/tb_wavetable_oscillator_interp_top.sv
